FILE: hw/rtl/ictp_pkg.sv
// ----------------------------------------------------------------------------
// ictp_pkg
// Shared types and codes of the indirect call target profiler: field widths,
// status and action codes, and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package ictp_pkg;

  localparam int SITE_ID_W   = 8;
  localparam int TARGET_W    = 48;
  localparam int SLOT_IDX_W  = 3;
  localparam int COUNT_W     = 32;
  localparam int CFG_W       = 4;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 120;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Action codes carried on in_tuser.
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Status codes carried on out_tuser.
  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;   // write one zero row during the clearing pass
    logic accept;   // capture the input beat and start the row read
    logic commit;   // write the row back and load the output register
  } ictp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last; // clearing pass is at its last row
    logic out_free; // output register can take a result this cycle
  } ictp_stat_t;

endpackage

FILE: hw/rtl/ictp_ram.sv
// ----------------------------------------------------------------------------
// ictp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module ictp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/ictp_ctrl.sv
// ----------------------------------------------------------------------------
// ictp_ctrl
// Controller of the profiler: runs the clearing pass after reset, then
// sequences each beat through a row read and a lookup with write back.
// ----------------------------------------------------------------------------
module ictp_ctrl
  import ictp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  ictp_stat_t stat,
  output ictp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_LOOKUP = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // Hold the read row until the output register has room.
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cmd.clr_wr = (state_r == S_CLEAR);
  assign cmd.accept = (state_r == S_IDLE) && in_tvalid;
  assign cmd.commit = (state_r == S_LOOKUP) && stat.out_free;

endmodule

FILE: hw/rtl/ictp_datapath.sv
// ----------------------------------------------------------------------------
// ictp_datapath
// Datapath of the profiler: site index reduction, the row and total
// memories, the parallel slot search, write back and the output register.
// ----------------------------------------------------------------------------
module ictp_datapath
  import ictp_pkg::*;
#(
  parameter int NUM_SITES   = 256,
  parameter int MAX_TARGETS = 8,
  parameter int ADDR_BITS   = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ictp_cmd_t              cmd,
  output ictp_stat_t             stat,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser
);

  localparam int SITE_W = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
  localparam int SLOT_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int TGT_W  = (ADDR_BITS < TARGET_W) ? ADDR_BITS : TARGET_W;
  localparam int ENT_W  = 1 + TGT_W + COUNT_W;
  localparam int ROW_W  = MAX_TARGETS * ENT_W;

  // Configuration.
  logic [CFG_W-1:0] cfg_r;
  logic [CFG_W-1:0] lim;

  // Captured beat.
  logic              act_r;
  logic [SITE_W-1:0] site_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [2:0]        rslot_r;

  logic [7:0]        site_rem;
  logic [SITE_W-1:0] site_mod;
  logic [SITE_W-1:0] clr_cnt_r;

  // Memories.
  logic [ROW_W-1:0]   row_rd;
  logic [ROW_W-1:0]   row_new;
  logic [COUNT_W-1:0] tot_rd;
  logic               mem_we;
  logic               rec_wr;
  logic [SITE_W-1:0]  mem_waddr;
  logic [ROW_W-1:0]   row_wdata;
  logic [COUNT_W-1:0] tot_wdata;

  // Slot search.
  logic [MAX_TARGETS-1:0] ent_occ;
  logic [TGT_W-1:0]       ent_tgt [MAX_TARGETS];
  logic [COUNT_W-1:0]     ent_cnt [MAX_TARGETS];
  logic                   found;
  logic                   hit_new;
  logic [SLOT_W-1:0]      hit_idx;
  logic [SLOT_W-1:0]      sel_idx;
  logic                   sel_occ;
  logic [TGT_W-1:0]       sel_tgt;
  logic [COUNT_W-1:0]     sel_cnt;
  logic [COUNT_W-1:0]     new_cnt;
  logic [COUNT_W-1:0]     new_tot;
  logic                   rd_in_rng;

  // Result.
  logic [1:0]          res_status;
  logic [2:0]          res_idx;
  logic                res_valid;
  logic [TARGET_W-1:0] res_target;
  logic [COUNT_W-1:0]  res_count;
  logic [COUNT_W-1:0]  res_total;

  logic                out_vld_r;
  logic [1:0]          out_status_r;
  logic [2:0]          out_idx_r;
  logic                out_valid_r;
  logic [TARGET_W-1:0] out_target_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [COUNT_W-1:0]  out_total_r;

  // Site index modulo NUM_SITES by restoring subtraction of shifted constants.
  always_comb begin
    site_rem = in_tdata[SITE_ID_W-1:0];
    for (int k = 7; k >= 0; k--) begin
      if ((NUM_SITES << k) <= 255) begin
        if (32'(site_rem) >= (NUM_SITES << k)) begin
          site_rem = site_rem - 8'(NUM_SITES << k);
        end
      end
    end
    site_mod = SITE_W'(site_rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clr_last = (clr_cnt_r == SITE_W'(NUM_SITES - 1));
  assign stat.out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r   <= in_tuser;
      site_r  <= site_mod;
      tgt_r   <= in_tdata[SITE_ID_W +: TGT_W];
      rslot_r <= in_tdata[SITE_ID_W + TARGET_W +: SLOT_IDX_W];
    end
  end

  // Row write port: zero rows during the clearing pass, else the updated row.
  assign rec_wr    = cmd.commit && (act_r == ACT_RECORD);
  assign mem_we    = cmd.clr_wr || rec_wr;
  assign mem_waddr = cmd.clr_wr ? clr_cnt_r : site_r;
  assign row_wdata = cmd.clr_wr ? '0 : row_new;
  assign tot_wdata = cmd.clr_wr ? '0 : new_tot;

  ictp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SITES)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (row_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (site_mod),
    .rd_data (row_rd)
  );

  ictp_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_SITES)
  ) u_tot_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (tot_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (site_mod),
    .rd_data (tot_rd)
  );

  always_comb begin
    for (int k = 0; k < MAX_TARGETS; k++) begin
      ent_cnt[k] = row_rd[k*ENT_W +: COUNT_W];
      ent_tgt[k] = row_rd[k*ENT_W + COUNT_W +: TGT_W];
      ent_occ[k] = row_rd[k*ENT_W + ENT_W - 1];
    end
  end

  assign lim = (32'(cfg_r) > MAX_TARGETS) ? CFG_W'(MAX_TARGETS) : cfg_r;

  // The first slot within the limit that is empty or holds the target wins.
  always_comb begin
    found   = 1'b0;
    hit_new = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < MAX_TARGETS; k++) begin
      if (!found && (k < int'(lim)) && (!ent_occ[k] || (ent_tgt[k] == tgt_r))) begin
        found   = 1'b1;
        hit_new = !ent_occ[k];
        hit_idx = SLOT_W'(k);
      end
    end
  end

  assign rd_in_rng = (32'(rslot_r) < MAX_TARGETS);
  assign sel_idx   = (act_r == ACT_READ) ? SLOT_W'(rslot_r) : hit_idx;
  assign sel_occ   = ent_occ[sel_idx];
  assign sel_tgt   = ent_tgt[sel_idx];
  assign sel_cnt   = ent_cnt[sel_idx];
  assign new_cnt   = sel_cnt + 1'b1;
  assign new_tot   = tot_rd + 1'b1;

  always_comb begin
    row_new = row_rd;
    if (found) begin
      row_new[hit_idx*ENT_W +: ENT_W] = {1'b1, tgt_r, new_cnt};
    end
  end

  always_comb begin
    if (act_r == ACT_READ) begin
      res_status = ST_READ;
      res_idx    = rslot_r;
      res_valid  = rd_in_rng && sel_occ;
      res_target = rd_in_rng ? TARGET_W'(sel_tgt) : '0;
      res_count  = rd_in_rng ? sel_cnt : '0;
      res_total  = tot_rd;
    end else if (found) begin
      res_status = hit_new ? ST_NEW : ST_MATCH;
      res_idx    = 3'(hit_idx);
      res_valid  = 1'b1;
      res_target = TARGET_W'(tgt_r);
      res_count  = new_cnt;
      res_total  = new_tot;
    end else begin
      res_status = ST_FULL;
      res_idx    = '0;
      res_valid  = 1'b0;
      res_target = '0;
      res_count  = '0;
      res_total  = new_tot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_valid_r  <= res_valid;
      out_target_r <= res_target;
      out_count_r  <= res_count;
      out_total_r  <= res_total;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_total_r, out_count_r, out_target_r, out_valid_r, out_idx_r};

endmodule

FILE: hw/rtl/indirect_call_target_profiler.sv
// ----------------------------------------------------------------------------
// indirect_call_target_profiler
// Per-call-site table of observed indirect call targets with hit counts and
// a running total per site.
// ----------------------------------------------------------------------------
// Each beat passes through a read of the site's whole slot row and its total
// from the row memory (registered read), then a lookup that searches all slots
// in parallel, writes the updated row back and loads the result register. The
// block takes no new beat until that lookup has completed; in_tready stays low
// meanwhile. A result waiting in the output register does not block the next
// beat from being taken; only its write back waits. After reset the block
// clears both memories one row a cycle, with in_tready low; configuration
// writes are taken during that time.
module indirect_call_target_profiler
  import ictp_pkg::*;
#(
  parameter int NUM_SITES   = 256,
  parameter int MAX_TARGETS = 8,
  parameter int ADDR_BITS   = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,   // slots_in_use
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // site_id, target_address, read_slot
  input  logic                   in_tuser,      // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // slot_index, slot_valid, slot_target, slot_count, site_total
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser      // status
);

  ictp_cmd_t  cmd;
  ictp_stat_t stat;

  ictp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ictp_datapath #(
    .NUM_SITES   (NUM_SITES),
    .MAX_TARGETS (MAX_TARGETS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

FILE: hw/rtl/ictp_checker.sv
// ----------------------------------------------------------------------------
// ictp_checker
// Port-level checks of the profiler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ictp_checker
  import ictp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // One beat at a time: the cycle after an input beat the block is busy.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in back-to-back cycles");

  // A full table reports no slot.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (out_tdata[83:0] == 84'd0))
    else $error("table full result carries slot data");

  // A freshly claimed slot is valid with a count of one.
  a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NEW) |-> out_tdata[3] && (out_tdata[83:52] == 32'd1))
    else $error("claimed slot not valid or count not one");

  // A matched slot is always a valid one.
  a_match_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_MATCH) |-> out_tdata[3])
    else $error("matched slot reported as empty");

endmodule

bind indirect_call_target_profiler ictp_checker u_ictp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: verif/ictp_profile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ictp_profile_checker
// Watches the input, output and configuration ports of the profiler. It keeps
// its own copy of the per-site slot table and the slot limit, works out the
// report for every accepted input beat and compares each output beat, field
// by field, with the oldest report still waiting.
// ----------------------------------------------------------------------------
module ictp_profile_checker
  import ictp_pkg::*;
#(
  parameter int NUM_SITES = 256,
  parameter int MAX_SLOTS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,
  output int                     failures,
  output int                     reports_pending
);

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  slot_valid;
    logic [TARGET_W-1:0]   slot_target;
    logic [COUNT_W-1:0]    slot_count;
    logic [COUNT_W-1:0]    site_total;
  } slot_report_t;

  logic [TARGET_W-1:0] slot_addr_mem [NUM_SITES][MAX_SLOTS];
  bit                  slot_used     [NUM_SITES][MAX_SLOTS];
  logic [COUNT_W-1:0]  slot_hits     [NUM_SITES][MAX_SLOTS];
  logic [COUNT_W-1:0]  site_calls    [NUM_SITES];
  logic [CFG_W-1:0]    slot_limit;
  slot_report_t        pending_reports [$];

  // Applies one beat to the table copy and returns the report it produces.
  function automatic slot_report_t predict_site_update(
      input logic act, input logic [SITE_ID_W-1:0] site,
      input logic [TARGET_W-1:0] addr, input logic [SLOT_IDX_W-1:0] rslot);
    slot_report_t rep;
    int           lim;
    bit           done;
    rep = '0;
    if (act == ACT_READ) begin
      rep.status      = ST_READ;
      rep.slot_index  = rslot;
      rep.slot_valid  = slot_used[site][rslot];
      rep.slot_target = slot_addr_mem[site][rslot];
      rep.slot_count  = slot_hits[site][rslot];
      rep.site_total  = site_calls[site];
      return rep;
    end
    // Limits above the row size search the whole row.
    lim = (slot_limit > MAX_SLOTS) ? MAX_SLOTS : int'(slot_limit);
    site_calls[site] = site_calls[site] + 1;
    done = 0;
    rep.status = ST_FULL;
    for (int i = 0; i < lim; i++) begin
      if (!done) begin
        if (!slot_used[site][i]) begin
          slot_used[site][i]     = 1;
          slot_addr_mem[site][i] = addr;
          rep.status = ST_NEW;
          done = 1;
        end else if (slot_addr_mem[site][i] == addr) begin
          rep.status = ST_MATCH;
          done = 1;
        end
        if (done) begin
          slot_hits[site][i] = slot_hits[site][i] + 1;
          rep.slot_index  = i[SLOT_IDX_W-1:0];
          rep.slot_valid  = 1'b1;
          rep.slot_target = addr;
          rep.slot_count  = slot_hits[site][i];
        end
      end
    end
    rep.site_total = site_calls[site];
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    slot_report_t want;
    slot_report_t got;
    if (!rst_n) begin
      foreach (slot_used[s, i]) begin
        slot_used[s][i]     = 0;
        slot_addr_mem[s][i] = '0;
        slot_hits[s][i]     = '0;
      end
      foreach (site_calls[s]) site_calls[s] = '0;
      slot_limit = CFG_RESET;
      pending_reports.delete();
      failures = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status      = out_tuser;
        got.slot_index  = out_tdata[2:0];
        got.slot_valid  = out_tdata[3];
        got.slot_target = out_tdata[51:4];
        got.slot_count  = out_tdata[83:52];
        got.site_total  = out_tdata[115:84];
        if (pending_reports.size() == 0) begin
          failures++;
          $display("%0t: output beat with nothing expected, status %0d data 0x%0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = pending_reports.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
          check_field("slot_valid", 64'(want.slot_valid), 64'(got.slot_valid));
          check_field("slot_target", 64'(want.slot_target), 64'(got.slot_target));
          check_field("slot_count", 64'(want.slot_count), 64'(got.slot_count));
          check_field("site_total", 64'(want.site_total), 64'(got.site_total));
        end
      end
      if (in_tvalid && in_tready)
        pending_reports.push_back(predict_site_update(in_tuser, in_tdata[7:0],
                                                      in_tdata[55:8], in_tdata[58:56]));
      if (cfg_wr_en)
        slot_limit = cfg_wr_data;
    end
    reports_pending = pending_reports.size();
  end

endmodule

FILE: verif/indirect_call_target_profiler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indirect_call_target_profiler_test
// Drives record and read beats into the profiler under several slot limits,
// with bursty input and a stalling receiver, and leaves all prediction and
// comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module indirect_call_target_profiler_test;
  import ictp_pkg::*;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int LONG_HOLD      = 300;
  localparam int BEATS_PER_STEP = 75;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // site_id, target_address, read_slot
  logic                   in_tuser;    // action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // slot_index, slot_valid, slot_target,
                                       // slot_count, site_total
  logic [1:0]             out_tuser;   // status

  int failures;
  int reports_pending;
  int results_taken = 0;
  int burst_left = 0;
  bit long_hold_done = 0;

  logic [TARGET_W-1:0] addr_pool [16];
  logic [CFG_W-1:0]    limit_steps [12] = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd2,
                                            4'd7, 4'd9, 4'd3, 4'd12, 4'd6, 4'd8};

  indirect_call_target_profiler i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  ictp_profile_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .failures        (failures),
    .reports_pending (reports_pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("indirect_call_target_profiler test failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) results_taken++;
  end

  // Receiver: switches at random among four stall patterns and once
  // holds off long enough for the block to back up into its input.
  initial begin
    int ready_mode;
    int mode_left;
    ready_mode = 0;
    mode_left = 0;
    out_tready = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_taken >= 150) begin
        long_hold_done = 1;
        out_tready = 0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (ready_mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 3) != 0);
        2: out_tready = ($urandom_range(0, 3) == 0);
        default: out_tready = ((mode_left % 8) < 5);
      endcase
    end
  end

  function automatic logic [TARGET_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TARGET_W-1:0];
  endfunction

  // Offers one beat and holds it until the block takes it.
  task automatic send_beat(input logic act, input logic [SITE_ID_W-1:0] site,
                           input logic [TARGET_W-1:0] addr,
                           input logic [SLOT_IDX_W-1:0] rslot);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {5'd0, rslot, addr, site};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (reports_pending != 0) @(negedge clk);
  endtask

  task automatic write_slot_limit(input logic [CFG_W-1:0] value);
    wait_for_drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly a handful of hot sites and a small set of targets, so that
  // matches, claims and full rows all occur; the rest is fully random.
  task automatic send_random_beat();
    logic [SITE_ID_W-1:0] site;
    logic [TARGET_W-1:0]  addr;
    int                   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    site = ($urandom_range(0, 9) < 7) ? SITE_ID_W'($urandom_range(0, 7))
                                      : SITE_ID_W'($urandom_range(0, 255));
    addr = ($urandom_range(0, 19) < 17) ? addr_pool[4'($urandom_range(0, 11))]
                                        : rand_addr();
    if ($urandom_range(0, 3) == 0)
      send_beat(ACT_READ, site, rand_addr(), SLOT_IDX_W'($urandom_range(0, 7)));
    else
      send_beat(ACT_RECORD, site, addr, SLOT_IDX_W'($urandom_range(0, 7)));
  endtask

  initial begin
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = ACT_RECORD;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 16; i++) addr_pool[i] = rand_addr();
    repeat (7) @(negedge clk);
    rst_n = 1;

    // Directed part under the reset limit: empty reads, address zero as a
    // real target, the last site, and a row filled to the point of overflow.
    send_beat(ACT_READ, 8'd0, '1, 3'd0);
    send_beat(ACT_RECORD, 8'd0, '0, 3'd7);
    send_beat(ACT_RECORD, 8'd0, '0, 3'd0);
    send_beat(ACT_RECORD, 8'd255, '1, 3'd0);
    send_beat(ACT_READ, 8'd255, '0, 3'd0);
    send_beat(ACT_READ, 8'd255, '0, 3'd7);
    for (int i = 0; i < 9; i++)
      send_beat(ACT_RECORD, 8'd1, addr_pool[i + 2], 3'd0);
    send_beat(ACT_READ, 8'd1, '0, 3'd7);
    send_beat(ACT_RECORD, 8'd1, addr_pool[9], 3'd0);
    // A zero limit searches nothing.
    write_slot_limit(4'd0);
    send_beat(ACT_RECORD, 8'd2, addr_pool[3], 3'd0);
    send_beat(ACT_READ, 8'd2, '0, 3'd0);
    // Limits above the row size saturate.
    write_slot_limit(4'd15);
    send_beat(ACT_RECORD, 8'd1, addr_pool[5], 3'd0);
    send_beat(ACT_RECORD, 8'd1, addr_pool[15], 3'd0);
    // With one slot, slots past the limit still read back normally.
    write_slot_limit(4'd1);
    send_beat(ACT_RECORD, 8'd0, addr_pool[4], 3'd0);
    send_beat(ACT_READ, 8'd1, '0, 3'd5);
    send_beat(ACT_RECORD, 8'd0, '0, 3'd0);

    foreach (limit_steps[p]) begin
      write_slot_limit(limit_steps[p]);
      burst_left = 0;
      repeat (BEATS_PER_STEP) send_random_beat();
    end

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (failures == 0 && reports_pending == 0)
      $display("indirect_call_target_profiler test passed");
    else
      $display("indirect_call_target_profiler test failed");
    $finish;
  end

endmodule
